@@ sv/pee_pkg.sv @@
package pee_pkg;

	localparam int StackDepth = 64;
	localparam int PtrW = $clog2(StackDepth);
	localparam int CntW = $clog2(StackDepth + 1);

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChAdd   = 8'h2B;
	localparam logic [7:0] ChSub   = 8'h2D;
	localparam logic [7:0] ChMul   = 8'h2A;
	localparam logic [7:0] ChDiv   = 8'h2F;
	localparam logic [7:0] ChMod   = 8'h25;
	localparam logic [7:0] ChPow   = 8'h24;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_RIGHT,
		ST_RD_LEFT,
		ST_CALC,
		ST_WAIT_ALU,
		ST_FINAL_RD,
		ST_EMIT
	} state_t;

	// request to the arithmetic unit
	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div0;
	} alu_rsp_t;

endpackage

@@ sv/pee_alu.sv @@
module pee_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pee_pkg::alu_req_t    req,
	input  logic [31:0]          left,
	input  logic [31:0]          right,
	output pee_pkg::alu_rsp_t    rsp,
	output logic [31:0]          result
);
	import pee_pkg::*;

	typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW, A_DONE} astate_t;

	astate_t     st_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q, rem_q, dvs_q, base_q, exp_q, acc_q, res_q;
	logic        neg_q_q, neg_r_q, is_mod_q, div0_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				A_IDLE: if (req.start) begin
					div0_q <= 1'b0;
					cnt_q  <= '0;
					case (req.op)
						OP_ADD: begin res_q <= left + right; st_q <= A_DONE; end
						OP_SUB: begin res_q <= left - right; st_q <= A_DONE; end
						OP_MUL: begin res_q <= left * right; st_q <= A_DONE; end
						OP_DIV, OP_MOD: begin
							if (right == '0) begin
								res_q  <= '0;
								div0_q <= 1'b1;
								st_q   <= A_DONE;
							end else begin
								quo_q    <= left[31] ? -left : left;
								rem_q    <= '0;
								dvs_q    <= right[31] ? -right : right;
								neg_q_q  <= left[31] ^ right[31];
								neg_r_q  <= left[31];
								is_mod_q <= (req.op == OP_MOD);
								st_q     <= A_DIV;
							end
						end
						OP_POW: begin
							if (right[31]) begin
								if (left == 32'd1) res_q <= 32'd1;
								else if (left == '1) res_q <= right[0] ? '1 : 32'd1;
								else res_q <= '0;
								st_q <= A_DONE;
							end else begin
								base_q <= left;
								exp_q  <= right;
								acc_q  <= 32'd1;
								st_q   <= A_POW;
							end
						end
						default: st_q <= A_DONE;
					endcase
				end
				A_DIV: begin
					// one restoring step per cycle
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						rem_q <= rem_q;
						quo_q <= quo_q;
						if (is_mod_q) res_q <= neg_r_q ? -rem_q : rem_q;
						else res_q <= neg_q_q ? -quo_q : quo_q;
						st_q <= A_DONE;
					end
				end
				A_POW: begin
					// multiply on even counts alternates with square on odd counts
					if (exp_q == '0) begin
						res_q <= acc_q;
						st_q  <= A_DONE;
					end else if (!cnt_q[0]) begin
						if (exp_q[0]) acc_q <= acc_q * base_q;
						cnt_q <= cnt_q ^ 6'd1;
					end else begin
						base_q <= base_q * base_q;
						exp_q  <= exp_q >> 1;
						cnt_q  <= cnt_q ^ 6'd1;
					end
				end
				A_DONE: st_q <= A_IDLE;
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == A_DONE);
	assign rsp.div0 = div0_q;
	assign result   = res_q;

endmodule

@@ sv/postfix_expression_evaluator.sv @@
// postfix expression evaluator
// input channel: ch/last with in_valid/in_stall; one ascii character per request,
// last marks the final character of an expression
// output channel: value plus four sticky flags with out_valid/out_stall; one
// request leaves the block after each character marked last
// digits, blanks and ignored characters are handled in the idle state; an
// operator pops two words from the stack ram (a registered read each) and runs the
// shared arithmetic unit: add/sub/mul, a zero divisor and a negative exponent
// go straight to the done state, divide/modulo forms one quotient bit a cycle,
// power multiplies and squares on alternating cycles, one exponent bit per square
// the final character adds a read of the stack top and a result register load
// one expression character is in flight at a time
// reset clears the stack count, the flags and the handshake state; stack words
// are not cleared, only entries below the count are ever read
// while the receiver stalls the result register holds its request; new input
// is still taken and only the next result waits until the register frees up
module postfix_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               overflow_seen,
	output logic               underflow_seen,
	output logic               bad_operator,
	output logic               divide_by_zero
);
	import pee_pkg::*;

	// stack storage, one write and one read port
	logic [31:0] mem [StackDepth];
	logic [31:0] rd_data_q;
	logic        rd_en;
	logic [PtrW-1:0] rd_addr;
	logic        wr_en;
	logic [PtrW-1:0] wr_addr;
	logic [31:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	state_t st_q, st_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic over_q, under_q, bad_q, div0_q;
	logic over_d, under_d, bad_d, div0_d;
	logic last_q, last_d;
	op_t  op_q, op_d;
	// read tags: the popped word is real, not an empty-stack zero
	logic rv_q, rv_d, lv_q, lv_d;
	logic [31:0] right_q, right_d;
	logic [31:0] left_op;
	logic [31:0] out_val_q, out_val_d;
	logic out_valid_q, out_valid_d;
	logic flags_over_q, flags_under_q, flags_bad_q, flags_div0_q;
	logic flags_over_d, flags_under_d, flags_bad_d, flags_div0_d;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic [31:0] alu_res;

	// left word arrives from the ram in the cycle the unit starts
	assign left_op = lv_q ? rd_data_q : '0;

	pee_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.left  (left_op),
		.right (right_q),
		.rsp   (alu_rsp),
		.result(alu_res)
	);

	logic in_acc;
	logic is_digit, is_blank, is_op;
	op_t  ch_op;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		is_digit = (ch >= ChZero) && (ch <= ChNine);
		is_blank = (ch == ChSpace) || (ch == ChTab);
		is_op    = 1'b1;
		ch_op    = OP_ADD;
		case (ch)
			ChAdd:   ch_op = OP_ADD;
			ChSub:   ch_op = OP_SUB;
			ChMul:   ch_op = OP_MUL;
			ChDiv:   ch_op = OP_DIV;
			ChMod:   ch_op = OP_MOD;
			ChPow:   ch_op = OP_POW;
			default: is_op = 1'b0;
		endcase
	end

	// sequencer: next state, stack ram ports and result loading
	always_comb begin
		st_d = st_q; cnt_d = cnt_q;
		over_d = over_q; under_d = under_q; bad_d = bad_q; div0_d = div0_q;
		last_d = last_q; op_d = op_q; rv_d = rv_q; lv_d = lv_q;
		right_d = right_q;
		out_val_d = out_val_q;
		out_valid_d = out_valid_q && out_stall;
		flags_over_d = flags_over_q; flags_under_d = flags_under_q;
		flags_bad_d = flags_bad_q; flags_div0_d = flags_div0_q;
		rd_en = 1'b0; rd_addr = PtrW'(cnt_q - 1'b1);
		wr_en = 1'b0; wr_addr = cnt_q[PtrW-1:0]; wr_data = alu_res;
		alu_req.start = 1'b0; alu_req.op = op_q;
		case (st_q)
			ST_IDLE: if (in_acc) begin
				last_d = last;
				st_d   = last ? ST_FINAL_RD : ST_IDLE;
				// after an unknown character everything up to last is ignored
				if (!bad_q) begin
					if (is_blank) begin
						// skipped
					end else if (is_digit) begin
						if (cnt_q == CntW'(StackDepth)) over_d = 1'b1;
						else begin
							wr_en   = 1'b1;
							wr_data = {24'd0, ch - ChZero};
							cnt_d   = cnt_q + 1'b1;
						end
					end else if (is_op) begin
						op_d = ch_op;
						st_d = ST_RD_RIGHT;
					end else bad_d = 1'b1;
				end
			end
			ST_RD_RIGHT: begin
				// pop right operand, empty stack gives zero
				rv_d = (cnt_q != '0);
				if (cnt_q == '0) under_d = 1'b1;
				else begin
					rd_en = 1'b1;
					cnt_d = cnt_q - 1'b1;
				end
				st_d = ST_RD_LEFT;
			end
			ST_RD_LEFT: begin
				// right data arrives now; pop left
				right_d = rv_q ? rd_data_q : '0;
				lv_d = (cnt_q != '0);
				if (cnt_q == '0) under_d = 1'b1;
				else begin
					rd_en = 1'b1;
					cnt_d = cnt_q - 1'b1;
				end
				st_d = ST_CALC;
			end
			ST_CALC: begin
				alu_req.start = 1'b1;
				st_d = ST_WAIT_ALU;
			end
			ST_WAIT_ALU: if (alu_rsp.done) begin
				if (alu_rsp.div0) div0_d = 1'b1;
				if (cnt_q == CntW'(StackDepth)) over_d = 1'b1;
				else begin
					wr_en = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
				st_d = last_q ? ST_FINAL_RD : ST_IDLE;
			end
			ST_FINAL_RD: begin
				// final pop of the top
				rv_d = (cnt_q != '0);
				if (cnt_q == '0) under_d = 1'b1;
				else rd_en = 1'b1;
				st_d = ST_EMIT;
			end
			ST_EMIT: if (!(out_valid_q && out_stall)) begin
				// result register is free: load it and clear the expression
				out_valid_d   = 1'b1;
				out_val_d     = rv_q ? rd_data_q : '0;
				flags_over_d  = over_q;
				flags_under_d = under_q;
				flags_bad_d   = bad_q;
				flags_div0_d  = div0_q;
				cnt_d = '0;
				over_d = 1'b0; under_d = 1'b0; bad_d = 1'b0; div0_d = 1'b0;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cnt_q <= '0;
			over_q <= 1'b0; under_q <= 1'b0; bad_q <= 1'b0; div0_q <= 1'b0;
			last_q <= 1'b0; op_q <= OP_ADD; rv_q <= 1'b0; lv_q <= 1'b0;
			right_q <= '0;
			out_val_q <= '0; out_valid_q <= 1'b0;
			flags_over_q <= 1'b0; flags_under_q <= 1'b0;
			flags_bad_q <= 1'b0; flags_div0_q <= 1'b0;
		end else begin
			st_q <= st_d; cnt_q <= cnt_d;
			over_q <= over_d; under_q <= under_d; bad_q <= bad_d; div0_q <= div0_d;
			last_q <= last_d; op_q <= op_d; rv_q <= rv_d; lv_q <= lv_d;
			right_q <= right_d;
			out_val_q <= out_val_d; out_valid_q <= out_valid_d;
			flags_over_q <= flags_over_d; flags_under_q <= flags_under_d;
			flags_bad_q <= flags_bad_d; flags_div0_q <= flags_div0_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = out_val_q;
	assign overflow_seen  = flags_over_q;
	assign underflow_seen = flags_under_q;
	assign bad_operator   = flags_bad_q;
	assign divide_by_zero = flags_div0_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(StackDepth)) else $error("stack count beyond depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall) else $error("request taken while busy");
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && !(out_valid_q && out_stall)) |=>
		(cnt_q == '0 && out_valid_q)) else $error("emit broken");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_val_q)))
		else $error("stalled result changed");

endmodule
